// ===== hw/rtl/sps_pkg.sv =====
package sps_pkg;

   localparam int DW = 100;
   localparam int QW = 33;
   localparam int RW = DW + QW;
   localparam int PRE_SHIFT = 17;

   localparam logic [QW-1:0] SAT_POS = 33'h07FFFFFFF;
   localparam logic [QW-1:0] SAT_NEG = 33'h080000000;

   typedef struct packed {
      logic                 ok;
      logic [DW-1:0]        dmag;
      logic [2:0]           neg;
      logic [2:0]           ovf;
      logic [2:0][DW-1:0]   nmag;
   } sps_job_type;

endpackage

// ===== hw/rtl/stokes_pixel_solver.sv =====
// Pipeline from req transfer to rsp transfer: 6 front stages, the queue,
// 33 divider stages, 1 output register. Throughput: one pixel per cycle
// unless stalled; the one-bit-per-stage divider pipeline and the cofactor
// multiplier pipeline both take a new pixel every cycle when not stalled.
// Reset clears all valid bits, the queue and det_floor; no clearing pass.
module stokes_pixel_solver import sps_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_m_r0c0,
   input  logic signed [31:0] req_m_r0c1,
   input  logic signed [31:0] req_m_r0c2,
   input  logic signed [31:0] req_m_r1c0,
   input  logic signed [31:0] req_m_r1c1,
   input  logic signed [31:0] req_m_r1c2,
   input  logic signed [31:0] req_m_r2c0,
   input  logic signed [31:0] req_m_r2c1,
   input  logic signed [31:0] req_m_r2c2,
   input  logic signed [31:0] req_acc_first,
   input  logic signed [31:0] req_acc_second,
   input  logic signed [31:0] req_acc_third,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_stokes_i,
   output logic signed [31:0] rsp_stokes_q,
   output logic signed [31:0] rsp_stokes_u,
   output logic               rsp_solved_ok
);

   logic [30:0]        floor_ff;
   logic signed [31:0] m [9];
   logic signed [31:0] d [3];
   logic               front_en;
   logic               front_valid;
   sps_job_type        front_job;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;
   sps_job_type        q_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
      end else if (csr_wr_en) begin
         floor_ff <= csr_wr_data;
      end
   end

   assign m[0] = req_m_r0c0;
   assign m[1] = req_m_r0c1;
   assign m[2] = req_m_r0c2;
   assign m[3] = req_m_r1c0;
   assign m[4] = req_m_r1c1;
   assign m[5] = req_m_r1c2;
   assign m[6] = req_m_r2c0;
   assign m[7] = req_m_r2c1;
   assign m[8] = req_m_r2c2;
   assign d[0] = req_acc_first;
   assign d[1] = req_acc_second;
   assign d[2] = req_acc_third;

   assign front_en  = !(q_full && front_valid);
   assign req_stall = !front_en;

   sps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (front_en),
      .in_valid  (req_valid),
      .m         (m),
      .d         (d),
      .det_floor (floor_ff),
      .out_valid (front_valid),
      .out_job   (front_job)
   );

   sps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_en && front_valid),
      .push_job (front_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (q_job)
   );

   sps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_job    (q_job),
      .in_pop    (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_i     (rsp_stokes_i),
      .out_q     (rsp_stokes_q),
      .out_u     (rsp_stokes_u),
      .out_ok    (rsp_solved_ok)
   );

endmodule

// ===== hw/rtl/sps_front.sv =====
module sps_front import sps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] m [9],
   input  logic signed [31:0] d [3],
   input  logic [30:0]        det_floor,
   output logic               out_valid,
   output sps_job_type        out_job
);

   logic [5:0]        v_ff;
   logic [4:0]        zero_ff;
   logic signed [63:0] pa_ff [9];
   logic signed [63:0] pb_ff [9];
   logic signed [31:0] mc0_ff [3];
   logic signed [31:0] d0_ff [3];
   logic signed [31:0] mc1_ff [3];
   logic signed [31:0] d1_ff [3];
   logic signed [64:0] cof_ff [9];
   logic signed [64:0] plo_ff [12];
   logic signed [64:0] phi_ff [12];
   logic signed [DW-1:0] prod_ff [12];
   logic signed [DW-1:0] sum_ff [4];
   sps_job_type       job_in;
   sps_job_type       job_ff;
   logic              zero_in;

   always_comb begin
      zero_in = 1'b0;
      for (int i = 0; i < 9; i++) begin
         if (m[i] == 32'sd0) zero_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= {zero_ff[3:0], zero_in};
         for (int r = 0; r < 3; r++) begin
            mc0_ff[r] <= m[r*3];
            d0_ff[r]  <= d[r];
            mc1_ff[r] <= mc0_ff[r];
            d1_ff[r]  <= d0_ff[r];
         end
         for (int t = 0; t < 4; t++) begin
            sum_ff[t] <= prod_ff[t*3] + prod_ff[t*3+1] + prod_ff[t*3+2];
         end
         job_ff <= job_in;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar k = 0; k < 3; k++) begin : g_col
         localparam int R1 = (r == 0) ? 1 : 0;
         localparam int R2 = (r == 2) ? 1 : 2;
         localparam int C1 = (k == 0) ? 1 : 0;
         localparam int C2 = (k == 2) ? 1 : 2;
         localparam bit ODD = ((r + k) % 2) == 1;
         localparam int A0 = R1*3 + (ODD ? C2 : C1);
         localparam int A1 = R2*3 + (ODD ? C1 : C2);
         localparam int B0 = R1*3 + (ODD ? C1 : C2);
         localparam int B1 = R2*3 + (ODD ? C2 : C1);

         always_ff @(posedge clock) begin
            if (en) begin
               pa_ff[r*3+k]  <= m[A0] * m[A1];
               pb_ff[r*3+k]  <= m[B0] * m[B1];
               cof_ff[r*3+k] <= 65'(pa_ff[r*3+k]) - 65'(pb_ff[r*3+k]);
            end
         end
      end
   end

   for (genvar t = 0; t < 4; t++) begin : g_term
      for (genvar r = 0; r < 3; r++) begin : g_r
         localparam int K = (t == 0) ? 0 : t - 1;
         logic signed [31:0] x;
         assign x = (t == 0) ? mc1_ff[r] : d1_ff[r];

         always_ff @(posedge clock) begin
            if (en) begin
               plo_ff[t*3+r]  <= x * $signed({1'b0, cof_ff[r*3+K][31:0]});
               phi_ff[t*3+r]  <= x * $signed(cof_ff[r*3+K][64:32]);
               prod_ff[t*3+r] <= (DW'(phi_ff[t*3+r]) <<< 32) + DW'(plo_ff[t*3+r]);
            end
         end
      end
   end

   always_comb begin
      logic          dneg;
      logic [DW-1:0] dmag;
      logic [DW-1:0] nmag;
      dneg = sum_ff[0][DW-1];
      dmag = dneg ? DW'(-sum_ff[0]) : DW'(sum_ff[0]);
      job_in.dmag = dmag;
      job_in.ok = !zero_ff[4] && (dmag > DW'({det_floor, 32'd0}));
      for (int l = 0; l < 3; l++) begin
         nmag = sum_ff[l+1][DW-1] ? DW'(-sum_ff[l+1]) : DW'(sum_ff[l+1]);
         job_in.nmag[l] = nmag;
         job_in.neg[l]  = sum_ff[l+1][DW-1] ^ dneg;
         job_in.ovf[l]  = {16'd0, nmag} >= {dmag, 16'd0};
      end
   end

   assign out_valid = v_ff[5];
   assign out_job   = job_ff;

endmodule

// ===== hw/rtl/sps_queue.sv =====
module sps_queue import sps_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  sps_job_type push_job,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output sps_job_type pop_job
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   sps_job_type   mem_ff [DEPTH];
   logic [AW-1:0] wr_ff;
   logic [AW-1:0] rd_ff;
   logic [CW-1:0] cnt_ff;

   assign full    = cnt_ff == CW'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign pop_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

// ===== hw/rtl/sps_back.sv =====
module sps_back import sps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  sps_job_type        in_job,
   output logic               in_pop,
   output logic               out_valid,
   input  logic               out_stall,
   output logic signed [31:0] out_i,
   output logic signed [31:0] out_q,
   output logic signed [31:0] out_u,
   output logic               out_ok
);

   localparam int NS = QW;

   logic              en;
   logic [NS-1:0]     vb_ff;
   logic [RW-1:0]     rem_ff [NS][3];
   logic [QW-1:0]     quo_ff [NS][3];
   logic [DW-1:0]     dm_ff [NS];
   logic              ok_ff [NS];
   logic [2:0]        neg_ff [NS];
   logic [2:0]        ovf_ff [NS];
   logic              valid_ff;
   logic signed [31:0] res_ff [3];
   logic              ok_out_ff;
   logic signed [31:0] res_in [3];

   assign en     = !(valid_ff && out_stall);
   assign in_pop = en && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff    <= '0;
         valid_ff <= 1'b0;
      end else if (en) begin
         vb_ff    <= {vb_ff[NS-2:0], in_valid};
         valid_ff <= vb_ff[NS-1];
      end
   end

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam int B = QW - 1 - j;
      logic [DW-1:0] din;
      if (j == 0) begin : g_first
         assign din = in_job.dmag;
         always_ff @(posedge clock) begin
            if (en) begin
               dm_ff[j]  <= in_job.dmag;
               ok_ff[j]  <= in_job.ok;
               neg_ff[j] <= in_job.neg;
               ovf_ff[j] <= in_job.ovf;
            end
         end
      end else begin : g_next
         assign din = dm_ff[j-1];
         always_ff @(posedge clock) begin
            if (en) begin
               dm_ff[j]  <= dm_ff[j-1];
               ok_ff[j]  <= ok_ff[j-1];
               neg_ff[j] <= neg_ff[j-1];
               ovf_ff[j] <= ovf_ff[j-1];
            end
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [RW-1:0] rin;
         logic [QW-1:0] qin;
         logic [QW-1:0] qout;
         logic [RW-1:0] dsh;
         logic          ge;
         if (j == 0) begin : g_init
            assign rin = RW'({in_job.nmag[l], {PRE_SHIFT{1'b0}}});
            assign qin = '0;
         end else begin : g_chain
            assign rin = rem_ff[j-1][l];
            assign qin = quo_ff[j-1][l];
         end
         assign dsh = RW'(din) << B;
         assign ge  = rin >= dsh;
         always_comb begin
            qout    = qin;
            qout[B] = ge;
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j][l] <= ge ? rin - dsh : rin;
               quo_ff[j][l] <= qout;
            end
         end
      end
   end

   always_comb begin
      logic [QW:0]   rnd;
      logic [QW-1:0] rq;
      logic [QW-1:0] limit;
      logic [31:0]   mag;
      for (int l = 0; l < 3; l++) begin
         rnd   = (QW+1)'(quo_ff[NS-1][l]) + 1'b1;
         rq    = rnd[QW:1];
         limit = neg_ff[NS-1][l] ? SAT_NEG : SAT_POS;
         mag   = (ovf_ff[NS-1][l] || rq > limit) ? limit[31:0] : rq[31:0];
         if (!ok_ff[NS-1]) begin
            res_in[l] = '0;
         end else begin
            res_in[l] = neg_ff[NS-1][l] ? -$signed(mag) : $signed(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) res_ff[l] <= res_in[l];
         ok_out_ff <= ok_ff[NS-1];
      end
   end

   assign out_valid = valid_ff;
   assign out_i     = res_ff[0];
   assign out_q     = res_ff[1];
   assign out_u     = res_ff[2];
   assign out_ok    = ok_out_ff;

endmodule

// ===== hw/rtl/sps_checker.sv =====
module sps_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_stokes_i,
   input logic signed [31:0] rsp_stokes_q,
   input logic signed [31:0] rsp_stokes_u,
   input logic               rsp_solved_ok
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_zero_when_unsolved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_solved_ok |->
         rsp_stokes_i == 32'sd0 && rsp_stokes_q == 32'sd0 && rsp_stokes_u == 32'sd0)
      else $error("unsolved pixel with nonzero components");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_stokes_i) && $stable(rsp_stokes_q)
         && $stable(rsp_stokes_u) && $stable(rsp_solved_ok))
      else $error("rsp payload changed while stalled");

endmodule

bind stokes_pixel_solver sps_checker u_checker (.*);
